/* rtl/ftr_pkg.sv */
// Shared types and constants for the fan tach RPM and duty slew unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ftr_pkg;

  localparam int DUTY_W = 15;
  localparam int RPM_W  = 14;
  localparam int PWM_W  = 9;
  localparam int PULSE_W = 10;
  localparam int LOCK_W  = 3;

  typedef logic [DUTY_W-1:0] duty_t;

  // operation codes
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_SET_GOAL = 2'd1;
  localparam logic [1:0] OP_SET_NOW  = 2'd2;

  // register indexes
  localparam logic CFG_RPM_METHOD = 1'b0;
  localparam logic CFG_MIN_DUTY   = 1'b1;

  localparam duty_t FULL_DUTY  = 15'd25600;
  localparam duty_t RESET_DUTY = 15'd12800;

  localparam logic [LOCK_W-1:0]  LOCKOUT_TICKS = 3'd5;
  localparam logic [PULSE_W-1:0] PULSE_MAX     = 10'd1023;
  localparam logic [RPM_W-1:0]   RPM_MAX       = 14'd16383;

  // step = diff * 3277 >> 16, at least 2 LSB
  localparam logic [11:0] STEP_MUL   = 12'd3277;
  localparam logic [10:0] STEP_FLOOR = 11'd2;

  // x / 100 as (x * 41944) >> 22, exact for any 15-bit x
  localparam logic [15:0] DIV100_MUL   = 16'd41944;
  localparam int          DIV100_SHIFT = 22;

  localparam int VOTE_TAPS_DEF        = 5;
  localparam int SMOOTH_PERIOD_MS_DEF = 200;
  localparam int RPM_WINDOW_MS_DEF    = 1000;

  typedef struct packed {
    logic [1:0] operation;
    logic       tach_level;
    duty_t      duty_cmd;
  } item_t;

endpackage

/* rtl/fan_tach_rpm_and_duty_slew_unit.sv */
// Top level: input register, tach and duty units, result handshake, PWM compare.
// Depends on ftr_pkg, ftr_tach and ftr_duty.
//
//   port group   dir  handshake             payload
//   in           in   in_valid / in_ready   operation, tach_level, duty_cmd
//   out          out  out_valid / out_ready pwm_compare, current_duty, target_duty, fan_rpm
//   cfg          in   cfg_write             cfg_index, cfg_data
//
// One word per clock while out_ready holds; result valid rises when the input word fires.
// The state registers double as the result register; they update as a word leaves the
// input register, which happens only when the result slot is free.
// A stalled result holds both stages; in_ready drops only when the input register is full.
// Synchronous active-high reset: duty 50 percent, counters zero, lockout saturated.
`timescale 1ns / 1ps

module fan_tach_rpm_and_duty_slew_unit import ftr_pkg::*; #(
  parameter int VOTE_TAPS        = VOTE_TAPS_DEF,
  parameter int SMOOTH_PERIOD_MS = SMOOTH_PERIOD_MS_DEF,
  parameter int RPM_WINDOW_MS    = RPM_WINDOW_MS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       operation,
  input  logic             tach_level,
  input  duty_t            duty_cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PWM_W-1:0] pwm_compare,
  output duty_t            current_duty,
  output duty_t            target_duty,
  output logic [RPM_W-1:0] fan_rpm,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  duty_t            cfg_data
);

  item_t       a_item;
  logic        a_valid, fire, in_take;
  logic        rpm_method;
  duty_t       min_duty;
  logic [30:0] pwm_prod;

  assign fire     = a_valid && (!out_valid || out_ready);
  assign in_ready = !a_valid || fire;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        a_valid <= 1'b1;
      end else if (fire) begin
        a_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_item <= '{operation: operation, tach_level: tach_level, duty_cmd: duty_cmd};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rpm_method <= 1'b0;
      min_duty   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_RPM_METHOD: rpm_method <= cfg_data[0];
        CFG_MIN_DUTY:   min_duty   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ftr_tach #(
    .VOTE_TAPS    (VOTE_TAPS),
    .RPM_WINDOW_MS(RPM_WINDOW_MS)
  ) u_tach (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (a_item),
    .rpm_method(rpm_method),
    .rpm_value (fan_rpm)
  );

  ftr_duty #(
    .SMOOTH_PERIOD_MS(SMOOTH_PERIOD_MS)
  ) u_duty (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .item     (a_item),
    .min_duty (min_duty),
    .duty_now (current_duty),
    .duty_goal(target_duty)
  );

  // divide by 100 through the reciprocal
  assign pwm_prod    = 31'(current_duty) * 31'(DIV100_MUL);
  assign pwm_compare = pwm_prod[DIV100_SHIFT +: PWM_W];

`ifndef SYNTHESIS
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    current_duty <= FULL_DUTY && target_duty <= FULL_DUTY)
    else $error("duty out of range");

  a_hold_state: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(current_duty) && $stable(target_duty) && $stable(fan_rpm))
    else $error("state moved without a word");

  a_full_take: assert property (@(posedge clk) disable iff (rst)
    (in_take && a_valid) |-> fire)
    else $error("input register overwritten");

  a_pwm_range: assert property (@(posedge clk) disable iff (rst)
    pwm_compare <= 9'd256)
    else $error("pwm compare out of range");
`endif

endmodule

/* rtl/ftr_tach.sv */
// Tach pulse detection (lockout edge and majority vote) and RPM window.
// Depends on ftr_pkg.
`timescale 1ns / 1ps

module ftr_tach import ftr_pkg::*; #(
  parameter int VOTE_TAPS     = VOTE_TAPS_DEF,
  parameter int RPM_WINDOW_MS = RPM_WINDOW_MS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  item_t            item,
  input  logic             rpm_method,
  output logic [RPM_W-1:0] rpm_value
);

  localparam int CNT_W     = $clog2(VOTE_TAPS + 1);
  localparam int WIN_W     = $clog2(RPM_WINDOW_MS);
  localparam int RPM_SCALE = 60000 / RPM_WINDOW_MS;
  localparam int PROD_W    = 20;

  logic [VOTE_TAPS-1:0] sample_window, sample_window_next;
  logic                 last_vote, last_raw_level;
  logic [LOCK_W-1:0]    lockout_ms, lockout_ms_next, lock_inc;
  logic [PULSE_W-1:0]   pulse_count, pulse_after;
  logic [WIN_W-1:0]     window_ms;
  logic [CNT_W-1:0]     highs;
  logic                 tick, level, vote, raw_edge, vote_edge, add, win_last;
  logic [PROD_W-1:0]    rpm_raw;
  logic [RPM_W-1:0]     rpm_sat;

  assign tick  = fire && (item.operation == OP_TICK);
  assign level = item.tach_level;

  always_comb begin
    lock_inc = (lockout_ms < LOCKOUT_TICKS) ? lockout_ms + 1'b1 : lockout_ms;
    raw_edge = level && !last_raw_level && (lock_inc >= LOCKOUT_TICKS);
    lockout_ms_next = raw_edge ? '0 : lock_inc;
  end

  assign sample_window_next = {sample_window[VOTE_TAPS-2:0], level};

  always_comb begin
    highs = '0;
    for (int i = 0; i < VOTE_TAPS; i++) begin
      highs = highs + CNT_W'(sample_window_next[i]);
    end
  end

  assign vote      = (highs >= CNT_W'(VOTE_TAPS / 2 + 1));
  assign vote_edge = vote && !last_vote;
  assign add       = rpm_method ? vote_edge : raw_edge;

  // detection lands before the window closes on the same tick
  assign pulse_after = (add && (pulse_count != PULSE_MAX)) ? pulse_count + 1'b1 : pulse_count;
  assign win_last    = (window_ms == WIN_W'(RPM_WINDOW_MS - 1));
  assign rpm_raw     = PROD_W'(pulse_after[PULSE_W-1:1]) * PROD_W'(RPM_SCALE);
  assign rpm_sat     = (rpm_raw > PROD_W'(RPM_MAX)) ? RPM_MAX : rpm_raw[RPM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_window  <= '0;
      last_vote      <= 1'b0;
      last_raw_level <= 1'b0;
      lockout_ms     <= LOCKOUT_TICKS;
      pulse_count    <= '0;
      window_ms      <= '0;
      rpm_value      <= '0;
    end else if (tick) begin
      sample_window  <= sample_window_next;
      last_vote      <= vote;
      last_raw_level <= level;
      lockout_ms     <= lockout_ms_next;
      if (win_last) begin
        window_ms   <= '0;
        pulse_count <= '0;
        rpm_value   <= rpm_sat;
      end else begin
        window_ms   <= window_ms + 1'b1;
        pulse_count <= pulse_after;
      end
    end
  end

endmodule

/* rtl/ftr_duty.sv */
// Duty command clamp and periodic slew of the present duty toward the target.
// Depends on ftr_pkg.
`timescale 1ns / 1ps

module ftr_duty import ftr_pkg::*; #(
  parameter int SMOOTH_PERIOD_MS = SMOOTH_PERIOD_MS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  fire,
  input  item_t item,
  input  duty_t min_duty,
  output duty_t duty_now,
  output duty_t duty_goal
);

  localparam int SM_W = $clog2(SMOOTH_PERIOD_MS + 1);

  logic [SM_W-1:0] smooth_ms;
  logic            tick, slew_due;
  duty_t           lo, vclip, clamped, diff, step_w, slewed;
  logic [26:0]     prod;
  logic [10:0]     step_raw, step;

  assign tick     = fire && (item.operation == OP_TICK);
  assign slew_due = (smooth_ms == SM_W'(SMOOTH_PERIOD_MS - 1));

  always_comb begin
    lo      = (min_duty > FULL_DUTY) ? FULL_DUTY : min_duty;
    vclip   = (item.duty_cmd > FULL_DUTY) ? FULL_DUTY : item.duty_cmd;
    clamped = (vclip < lo) ? lo : vclip;
  end

  always_comb begin
    diff     = (duty_goal > duty_now) ? duty_goal - duty_now : duty_now - duty_goal;
    prod     = 27'(diff) * 27'(STEP_MUL);
    step_raw = prod[26:16];
    step     = (step_raw < STEP_FLOOR) ? STEP_FLOOR : step_raw;
    step_w   = DUTY_W'(step);
    // never step past the target
    if (step_w >= diff) begin
      slewed = duty_goal;
    end else if (duty_goal > duty_now) begin
      slewed = duty_now + step_w;
    end else begin
      slewed = duty_now - step_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_ms <= '0;
      duty_now  <= RESET_DUTY;
      duty_goal <= RESET_DUTY;
    end else if (fire) begin
      case (item.operation)
        OP_TICK: begin
          if (slew_due) begin
            smooth_ms <= '0;
            duty_now  <= slewed;
          end else begin
            smooth_ms <= smooth_ms + 1'b1;
          end
        end
        OP_SET_GOAL: begin
          duty_goal <= clamped;
        end
        OP_SET_NOW: begin
          duty_goal <= clamped;
          duty_now  <= clamped;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* tb/sv/fan_duty_rpm_checker.sv */
// Checker for the fan tach RPM and duty slew unit: mirrors the tach counters,
// the duty slew and the register file, and compares every result word.
// Depends on ftr_pkg only; the testbench top instantiates it beside the block.
`timescale 1ns / 1ps

module fan_duty_rpm_checker import ftr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [1:0]       operation,
  input  logic             tach_level,
  input  duty_t            duty_cmd,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [PWM_W-1:0] pwm_compare,
  input  duty_t            current_duty,
  input  duty_t            target_duty,
  input  logic [RPM_W-1:0] fan_rpm,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  duty_t            cfg_data,
  output int               mismatches,
  output int               outstanding
);

  localparam int TAPS = VOTE_TAPS_DEF;

  typedef struct packed {
    logic [PWM_W-1:0] pwm;
    duty_t            cur;
    duty_t            goal;
    logic [RPM_W-1:0] rpm;
  } fan_status_t;

  fan_status_t status_due[$];
  int          mism_n = 0;

  // mirrored registers
  logic  vote_mode;
  duty_t duty_floor;

  // mirrored state
  logic [TAPS-1:0]    tach_hist;
  logic               vote_prev;
  logic               level_prev;
  logic [LOCK_W-1:0]  lock_age;
  logic [PULSE_W-1:0] edge_count;
  logic [RPM_W-1:0]   rpm_now;
  int unsigned        slew_age;
  int unsigned        window_age;
  duty_t              duty_cur;
  duty_t              duty_goal;

  assign mismatches = mism_n;

  task automatic clear_fan_state();
    vote_mode  = 1'b0;
    duty_floor = '0;
    tach_hist  = '0;
    vote_prev  = 1'b0;
    level_prev = 1'b0;
    lock_age   = LOCKOUT_TICKS;
    edge_count = '0;
    rpm_now    = '0;
    slew_age   = 0;
    window_age = 0;
    duty_cur   = RESET_DUTY;
    duty_goal  = RESET_DUTY;
  endtask

  function automatic duty_t limit_duty(duty_t v);
    duty_t lo;
    lo = (duty_floor > FULL_DUTY) ? FULL_DUTY : duty_floor;
    if (v > FULL_DUTY) v = FULL_DUTY;
    if (v < lo) v = lo;
    return v;
  endfunction

  function automatic void slew_toward_goal();
    int unsigned gap;
    int unsigned step;
    if (duty_goal == duty_cur) return;
    gap  = (duty_goal > duty_cur) ? duty_goal - duty_cur : duty_cur - duty_goal;
    step = (gap * STEP_MUL) >> 16;
    if (step < STEP_FLOOR) step = STEP_FLOOR;
    if (step >= gap) duty_cur = duty_goal;
    else if (duty_goal > duty_cur) duty_cur = duty_cur + duty_t'(step);
    else duty_cur = duty_cur - duty_t'(step);
  endfunction

  function automatic void count_tach(logic lvl);
    logic        raw_hit;
    logic        vote;
    int unsigned rpm_calc;
    if (lock_age < LOCKOUT_TICKS) lock_age++;
    raw_hit = lvl && !level_prev && (lock_age >= LOCKOUT_TICKS);
    if (raw_hit) lock_age = '0;
    level_prev = lvl;
    tach_hist  = {tach_hist[TAPS-2:0], lvl};
    vote = ($countones(tach_hist) >= TAPS / 2 + 1);
    // only the selected detector adds to the count, both keep tracking
    if ((raw_hit && !vote_mode) || (vote && !vote_prev && vote_mode))
      if (edge_count < PULSE_MAX) edge_count++;
    vote_prev = vote;

    slew_age++;
    if (slew_age >= SMOOTH_PERIOD_MS_DEF) begin
      slew_age = 0;
      slew_toward_goal();
    end

    window_age++;
    if (window_age >= RPM_WINDOW_MS_DEF) begin
      rpm_calc   = (edge_count / 2) * (60000 / RPM_WINDOW_MS_DEF);
      window_age = 0;
      edge_count = '0;
      rpm_now    = (rpm_calc > RPM_MAX) ? RPM_MAX : RPM_W'(rpm_calc);
    end
  endfunction

  function automatic fan_status_t apply_fan_word(logic [1:0] op, logic lvl, duty_t dv);
    fan_status_t s;
    if (op == OP_TICK) begin
      count_tach(lvl);
    end else if (op == OP_SET_GOAL) begin
      duty_goal = limit_duty(dv);
    end else if (op == OP_SET_NOW) begin
      duty_goal = limit_duty(dv);
      duty_cur  = duty_goal;
    end
    s.pwm  = PWM_W'(duty_cur / 100);
    s.cur  = duty_cur;
    s.goal = duty_goal;
    s.rpm  = rpm_now;
    return s;
  endfunction

  task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mism_n++;
    end
  endtask

  always @(posedge clk) begin : watch
    fan_status_t want;
    if (rst) begin
      clear_fan_state();
      status_due.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_RPM_METHOD) vote_mode = cfg_data[0];
        else duty_floor = cfg_data;
      end
      // compare before queuing this edge's word: no word is answered on the edge that takes it
      if (out_valid && out_ready) begin
        if (status_due.size() == 0) begin
          $error("result word with nothing expected");
          mism_n++;
        end else begin
          want = status_due.pop_front();
          check_field("pwm_compare", 16'(want.pwm), 16'(pwm_compare));
          check_field("current_duty", 16'(want.cur), 16'(current_duty));
          check_field("target_duty", 16'(want.goal), 16'(target_duty));
          check_field("fan_rpm", 16'(want.rpm), 16'(fan_rpm));
        end
      end
      if (in_valid && in_ready)
        status_due.push_back(apply_fan_word(operation, tach_level, duty_cmd));
    end
    outstanding <= status_due.size();
  end

endmodule

/* tb/sv/tb_fan_tach_rpm_and_duty_slew_unit.sv */
// Testbench top for the fan tach RPM and duty slew unit: clock, reset, register
// writes, directed and random words under several idle/stall mixes, and the verdict.
// Depends on ftr_pkg, the block and fan_duty_rpm_checker.
`timescale 1ns / 1ps

module tb_fan_tach_rpm_and_duty_slew_unit;
  import ftr_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 60;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       operation = OP_TICK;
  logic             tach_level = 1'b0;
  duty_t            duty_cmd = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [PWM_W-1:0] pwm_compare;
  duty_t            current_duty;
  duty_t            target_duty;
  logic [RPM_W-1:0] fan_rpm;
  logic             cfg_write = 1'b0;
  logic             cfg_index = CFG_RPM_METHOD;
  duty_t            cfg_data = '0;

  int mismatches;
  int outstanding;

  int src_idle = 0;
  int sink_stall = 0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int hold_left = 0;

  logic  tach_sq = 1'b0;
  int    tach_run = 0;
  duty_t last_dv = RESET_DUTY;

  always #2 clk = ~clk;

  fan_tach_rpm_and_duty_slew_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .tach_level(tach_level), .duty_cmd(duty_cmd),
    .out_valid(out_valid), .out_ready(out_ready),
    .pwm_compare(pwm_compare), .current_duty(current_duty),
    .target_duty(target_duty), .fan_rpm(fan_rpm),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fan_duty_rpm_checker u_fan_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .tach_level(tach_level), .duty_cmd(duty_cmd),
    .out_valid(out_valid), .out_ready(out_ready),
    .pwm_compare(pwm_compare), .current_duty(current_duty),
    .target_duty(target_duty), .fan_rpm(fan_rpm),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // result side: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= sink_stall);
    end
  end

  initial begin
    #2_000_000;
    $display("fan_tach_rpm_and_duty_slew_unit: mismatch");
    $finish;
  end

  task automatic send_word(logic [1:0] op, logic lvl, duty_t dv);
    while ($urandom_range(99, 0) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    tach_level <= lvl;
    duty_cmd   <= dv;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(logic idx, duty_t val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // drop valid and wait until every result word has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // square wave with random half periods, some long, plus sample noise
  function automatic logic next_tach();
    if (tach_run == 0) begin
      tach_sq  = ~tach_sq;
      tach_run = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
    end
    tach_run--;
    if ($urandom_range(19, 0) == 0) return 1'($urandom);
    return tach_sq;
  endfunction

  function automatic duty_t pick_duty();
    duty_t v;
    case ($urandom_range(9, 0))
      0, 1: v = duty_t'(int'(last_dv) + int'($urandom_range(6, 0)) - 3);
      2: begin
        case ($urandom_range(3, 0))
          0: v = '0;
          1: v = FULL_DUTY;
          2: v = FULL_DUTY + 15'd1;
          default: v = '1;
        endcase
      end
      3: v = duty_t'($urandom);
      default: v = duty_t'($urandom_range(FULL_DUTY, 0));
    endcase
    last_dv = v;
    return v;
  endfunction

  task automatic send_random();
    int         pick;
    logic [1:0] op;
    if ($urandom_range(999, 0) < 14) begin
      pick = $urandom_range(5, 0);
      op = (pick < 3) ? OP_SET_GOAL : (pick < 5) ? OP_SET_NOW : OP_UNUSED;
      send_word(op, 1'($urandom), pick_duty());
    end else begin
      send_word(OP_TICK, next_tach(), duty_t'($urandom));
    end
  endtask

  task automatic run_phase(logic method, duty_t floor_val, int s_idle, int r_stall, int n);
    write_reg(CFG_RPM_METHOD, duty_t'(method));
    write_reg(CFG_MIN_DUTY, floor_val);
    src_idle   = s_idle;
    sink_stall = r_stall;
    repeat (n) send_random();
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: clamps, unused operation, lockout around the first edges
    write_reg(CFG_RPM_METHOD, '0);
    write_reg(CFG_MIN_DUTY, 15'd3000);
    send_word(OP_SET_GOAL, 1'b0, '1);
    send_word(OP_SET_GOAL, 1'b1, FULL_DUTY);
    send_word(OP_SET_GOAL, 1'b0, '0);
    send_word(OP_SET_NOW, 1'b0, 15'd100);
    send_word(OP_SET_NOW, 1'b1, FULL_DUTY + 15'd1);
    send_word(OP_UNUSED, 1'b1, 15'd12345);
    send_word(OP_TICK, 1'b1, '0);
    send_word(OP_TICK, 1'b0, '1);
    send_word(OP_TICK, 1'b1, '0);
    send_word(OP_TICK, 1'b0, '0);
    send_word(OP_TICK, 1'b0, '0);
    send_word(OP_TICK, 1'b0, '0);
    send_word(OP_TICK, 1'b1, '0);
    send_word(OP_TICK, 1'b1, '0);
    send_word(OP_TICK, 1'b0, '0);
    send_word(OP_TICK, 1'b1, '0);
    send_word(OP_SET_GOAL, 1'b0, RESET_DUTY);
    send_word(OP_SET_NOW, 1'b0, '0);
    drain();

    run_phase(1'b0, '0, 0, 0, 130);
    run_phase(1'b1, 15'd6400, 85, 0, 130);
    run_phase(1'b0, FULL_DUTY, 0, 85, 130);
    run_phase(1'b1, '1, 21, 21, 130);

    // hold the result side off while words keep coming, so the input stalls
    write_reg(CFG_RPM_METHOD, 15'd1);
    write_reg(CFG_MIN_DUTY, '0);
    src_idle   = 0;
    sink_stall = 0;
    hold_req  <= ~hold_req;
    repeat (40) send_random();
    repeat (60) send_random();
    drain();
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("fan_tach_rpm_and_duty_slew_unit: match");
    end else begin
      $display("fan_tach_rpm_and_duty_slew_unit: mismatch");
    end
    $finish;
  end

endmodule
